// ===== rtl/gtl_pkg.sv =====
// Shared types, constants and helper functions of the GBK text layout engine.
package gtl_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CMP_W          = 18;
    localparam int IDX_W          = 15;
    localparam int OFFS_W         = 21;
    localparam int LEN_W          = 7;
    localparam int CFG_W          = 16;

    localparam logic [7:0]  CHAR_NUL       = 8'h00;
    localparam logic [7:0]  CHAR_CR        = 8'd13;
    localparam logic [7:0]  LEAD_THRESH    = 8'h80;
    localparam logic [7:0]  GBK_LEAD_MIN   = 8'h81;
    localparam logic [7:0]  TRAIL_MIN      = 8'h40;
    localparam logic [7:0]  TRAIL_HI_BASE  = 8'h41;
    localparam logic [7:0]  TRAIL_GAP      = 8'h7f;
    localparam logic [7:0]  BYTE_FF        = 8'hff;
    localparam logic [7:0]  GBK_TRAIL_SPAN = 8'd190;

    localparam logic [15:0] RESET_WIDTH  = 16'd128;
    localparam logic [15:0] RESET_HEIGHT = 16'd64;
    localparam logic [1:0]  RESET_FONT   = 2'd1;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_BLANK  = 2'd2,
        KIND_FULL   = 2'd3
    } cmd_kind_t;

    typedef enum logic [1:0] {
        CFG_REGION_WIDTH  = 2'd0,
        CFG_REGION_HEIGHT = 2'd1,
        CFG_FONT_SIZE     = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        string_start;
        logic [15:0] start_x;
        logic [15:0] start_y;
    } in_item_t;

    typedef struct packed {
        cmd_kind_t         cmd_kind;
        logic [15:0]       pos_x;
        logic [15:0]       pos_y;
        logic [15:0]       char_code;
        logic [OFFS_W-1:0] font_offset;
        logic [LEN_W-1:0]  glyph_bytes;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic res_pending;
        logic out_free;
    } dp_status_t;

    function automatic logic [4:0] font_height(input logic [1:0] sel);
        case (sel)
            2'd0:    font_height = 5'd12;
            2'd1:    font_height = 5'd16;
            default: font_height = 5'd24;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] bitmap_len(input logic [1:0] sel);
        case (sel)
            2'd0:    bitmap_len = 7'd24;
            2'd1:    bitmap_len = 7'd32;
            default: bitmap_len = 7'd72;
        endcase
    endfunction

endpackage

// ===== rtl/gtl_in_if.sv =====
// Request channel carrying one text byte and its string start information.
interface gtl_in_if;
    import gtl_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gtl_out_if.sv =====
// Request channel carrying one layout command.
interface gtl_out_if;
    import gtl_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gtl_ctrl.sv =====
// Sequencer: capture a request, run the layout step, then hand off the command.
module gtl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  gtl_pkg::dp_status_t    sts,
    output gtl_pkg::ctrl_cmd_t     cmd
);
    import gtl_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!sts.res_pending || sts.out_free)
                begin
                    cmd.fin  = 1'b1;
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/gtl_dp.sv =====
// Datapath: configuration, pen state, wrap and bound tests, font offset and output register.
module gtl_dp #(
    parameter int COORD_BITS = gtl_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gtl_pkg::ctrl_cmd_t        cmd,
    output gtl_pkg::dp_status_t       sts,
    input  gtl_pkg::in_item_t         in_data,
    input  logic                      out_ready,
    output logic                      out_valid,
    output gtl_pkg::out_item_t        out_data,
    input  logic                      cfg_we,
    input  gtl_pkg::cfg_idx_t         cfg_idx,
    input  logic [gtl_pkg::CFG_W-1:0] cfg_wdata
);
    import gtl_pkg::*;

    // configuration
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  font_reg;

    // captured request
    in_item_t in_reg;

    // layout state
    logic [COORD_BITS-1:0] pen_x_reg, pen_x_next;
    logic [COORD_BITS-1:0] pen_y_reg, pen_y_next;
    logic [COORD_BITS-1:0] org_x_reg, org_x_next;
    logic [COORD_BITS-1:0] org_y_reg, org_y_next;
    logic [7:0]            lead_reg, lead_next;
    logic                  lead_pend_reg, lead_pend_next;
    logic                  swallow_reg, swallow_next;
    logic                  halted_reg, halted_next;

    // pending result
    logic                  res_valid_reg, res_valid_next;
    cmd_kind_t             res_kind_reg, res_kind_next;
    logic [COORD_BITS-1:0] res_px_reg, res_px_next;
    logic [COORD_BITS-1:0] res_py_reg, res_py_next;
    logic [15:0]           res_code_reg, res_code_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic [LEN_W-1:0]      res_len_reg, res_len_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg;
    logic [IDX_W+LEN_W-1:0] offs_full;

    // step terms
    logic [COORD_BITS-1:0] ox, oy, px, py, px_p, py_p;
    logic [7:0]            lead_c;
    logic                  lp_c, sw_c, halt_c;
    logic [7:0]            b;
    logic [4:0]            h, w;
    logic [LEN_W-1:0]      blen;
    logic                  wrap, fits, bad_pair;
    logic [7:0]            ql;
    logic [15:0]           idx_full;
    logic [15:0]           code_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            font_reg   <= RESET_FONT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_REGION_WIDTH:  width_reg  <= cfg_wdata[15:0];
                CFG_REGION_HEIGHT: height_reg <= cfg_wdata[15:0];
                CFG_FONT_SIZE:     font_reg   <= cfg_wdata[1:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
    end

    always_comb
    begin
        b    = in_reg.text_byte;
        h    = font_height(font_reg);
        blen = bitmap_len(font_reg);

        ox     = org_x_reg;
        oy     = org_y_reg;
        px     = pen_x_reg;
        py     = pen_y_reg;
        lead_c = lead_reg;
        lp_c   = lead_pend_reg;
        sw_c   = swallow_reg;
        halt_c = halted_reg;
        if (in_reg.string_start)
        begin
            ox     = in_reg.start_x[COORD_BITS-1:0];
            oy     = in_reg.start_y[COORD_BITS-1:0];
            px     = in_reg.start_x[COORD_BITS-1:0];
            py     = in_reg.start_y[COORD_BITS-1:0];
            lead_c = 8'h00;
            lp_c   = 1'b0;
            sw_c   = 1'b0;
            halt_c = 1'b0;
        end

        w    = lp_c ? h : (h >> 1);
        wrap = (CMP_W'(px) + CMP_W'(w)) > (CMP_W'(ox) + CMP_W'(width_reg));
        px_p = wrap ? ox : px;
        py_p = wrap ? (py + COORD_BITS'(h)) : py;
        fits = !((CMP_W'(py_p) + CMP_W'(h)) > (CMP_W'(oy) + CMP_W'(height_reg)));

        bad_pair = (b < TRAIL_MIN) || (b == BYTE_FF) || (lead_c == BYTE_FF)
                   || (lead_c < GBK_LEAD_MIN);
        ql       = (b < TRAIL_GAP) ? (b - TRAIL_MIN) : (b - TRAIL_HI_BASE);
        idx_full = 16'(lead_c - GBK_LEAD_MIN) * 16'(GBK_TRAIL_SPAN) + 16'(ql);
        code_c   = lp_c ? {lead_c, b} : {8'h00, b};

        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        org_x_next     = org_x_reg;
        org_y_next     = org_y_reg;
        lead_next      = lead_reg;
        lead_pend_next = lead_pend_reg;
        swallow_next   = swallow_reg;
        halted_next    = halted_reg;
        res_valid_next = res_valid_reg;
        res_kind_next  = res_kind_reg;
        res_px_next    = res_px_reg;
        res_py_next    = res_py_reg;
        res_code_next  = res_code_reg;
        res_idx_next   = res_idx_reg;
        res_len_next   = res_len_reg;

        if (cmd.exec)
        begin
            pen_x_next     = px;
            pen_y_next     = py;
            org_x_next     = ox;
            org_y_next     = oy;
            lead_next      = lead_c;
            lead_pend_next = lp_c;
            swallow_next   = sw_c;
            halted_next    = halt_c;
            res_valid_next = 1'b0;
            res_px_next    = px_p;
            res_py_next    = py_p;
            res_code_next  = code_c;
            res_idx_next   = '0;
            res_len_next   = '0;
            res_kind_next  = KIND_SINGLE;

            if (!halt_c)
            begin
                if (b == CHAR_NUL)
                begin
                    halted_next    = 1'b1;
                    lead_pend_next = 1'b0;
                    swallow_next   = 1'b0;
                end
                else if (sw_c)
                begin
                    swallow_next = 1'b0;
                end
                else if (!lp_c && (b > LEAD_THRESH))
                begin
                    lead_next      = b;
                    lead_pend_next = 1'b1;
                end
                else
                begin
                    lead_pend_next = 1'b0;
                    pen_x_next     = px_p;
                    pen_y_next     = py_p;
                    if (!fits)
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = KIND_FULL;
                        halted_next    = 1'b1;
                        swallow_next   = 1'b0;
                    end
                    else if (lp_c)
                    begin
                        res_valid_next = 1'b1;
                        res_len_next   = blen;
                        if (bad_pair)
                        begin
                            res_kind_next = KIND_BLANK;
                        end
                        else
                        begin
                            res_kind_next = KIND_DOUBLE;
                            res_idx_next  = idx_full[IDX_W-1:0];
                        end
                        pen_x_next = px_p + COORD_BITS'(h);
                    end
                    else if (b == CHAR_CR)
                    begin
                        pen_y_next   = py_p + COORD_BITS'(h);
                        pen_x_next   = ox;
                        swallow_next = 1'b1;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        pen_x_next     = px_p + COORD_BITS'(h >> 1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            lead_reg      <= '0;
            lead_pend_reg <= 1'b0;
            swallow_reg   <= 1'b0;
            halted_reg    <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            org_x_reg     <= org_x_next;
            org_y_reg     <= org_y_next;
            lead_reg      <= lead_next;
            lead_pend_reg <= lead_pend_next;
            swallow_reg   <= swallow_next;
            halted_reg    <= halted_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg <= res_kind_next;
        res_px_reg   <= res_px_next;
        res_py_reg   <= res_py_next;
        res_code_reg <= res_code_next;
        res_idx_reg  <= res_idx_next;
        res_len_reg  <= res_len_next;
    end

    assign offs_full = (IDX_W+LEN_W)'(res_idx_reg) * (IDX_W+LEN_W)'(res_len_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin && res_valid_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin && res_valid_reg)
        begin
            out_data_reg.cmd_kind    <= res_kind_reg;
            out_data_reg.pos_x       <= 16'(res_px_reg);
            out_data_reg.pos_y       <= 16'(res_py_reg);
            out_data_reg.char_code   <= res_code_reg;
            out_data_reg.font_offset <= offs_full[OFFS_W-1:0];
            out_data_reg.glyph_bytes <= res_len_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;
    assign sts.res_pending = res_valid_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

endmodule

// ===== rtl/gbk_text_layout_engine_unit.sv =====
// GBK text layout engine: top level joining the sequencer and the datapath.
// Path: a byte is captured into the request register, stepped into the pending result registers,
// then handed into the output register; the next byte can be accepted during that hand-off,
// so acceptance is slower only while a pending command meets a held output register.
// Reset: pen, origin and pending lead cleared, engine halted until a string start,
// configuration back to width 128, height 64, 16-pixel font.
module gbk_text_layout_engine_unit #(
    parameter int COORD_BITS = gtl_pkg::COORD_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    gtl_in_if.sink                    in_ch,
    gtl_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  gtl_pkg::cfg_idx_t         cfg_idx,
    input  logic [gtl_pkg::CFG_W-1:0] cfg_wdata
);
    import gtl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    logic       in_ready;
    logic       out_valid;
    out_item_t  out_data;

    gtl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gtl_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_ch.data),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    assign in_ch.ready = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data  = out_data;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ready |=> cmd.exec)
        else $error("accepted request not executed");

    a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin && sts.res_pending |=> out_valid)
        else $error("pending command not delivered");

    a_fin_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin && sts.res_pending |-> !out_valid || out_ch.ready)
        else $error("output register overwritten");

    a_single_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.cmd_kind == KIND_SINGLE || out_data.cmd_kind == KIND_FULL)
        |-> out_data.font_offset == '0 && out_data.glyph_bytes == '0)
        else $error("offset or length set on a non-glyph command");

endmodule
